### hw/rtl/kmst_pkg.sv
`timescale 1ns / 1ps
package kmst_pkg;

  // fixed field widths
  localparam int VTX_W  = 6;
  localparam int WKEY_W = 16;
  localparam int KEY_W  = WKEY_W + 2 * VTX_W;
  localparam int SIZE_W = 7;
  localparam int COST_W = 22;

  // parameter defaults
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 1024;
  localparam int DEF_WEIGHT_BITS  = 16;

  // flips the weight sign bit so unsigned key order equals signed weight order
  localparam logic [WKEY_W-1:0] WKEY_FLIP = 16'h8000;

  // one disjoint-set entry
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [VTX_W-1:0]  parent;
  } set_ent_t;

  localparam int SET_W = SIZE_W + VTX_W;

endpackage

### hw/rtl/kmst_ram.sv
`timescale 1ns / 1ps
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/kruskal_minimum_spanning_tree_unit.sv
`timescale 1ns / 1ps
// Load: one edge transfer per cycle while collecting a graph.
// Run: each pass over the edge store finds the next larger key; one pass per distinct
// edge plus a final one, each pass but the final one followed by root walks through
// the set memory.
// Reset clears control state, edge count, cost and the forest valid bits; the edge store is not cleared.
module kruskal_minimum_spanning_tree_unit
  import kmst_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VTX_W-1:0]         in_src_vertex,
  input  logic [VTX_W-1:0]         in_dst_vertex,
  input  logic signed [WKEY_W-1:0] in_edge_weight,
  input  logic                     in_last_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [VTX_W-1:0]         out_tree_src,
  output logic [VTX_W-1:0]         out_tree_dst,
  output logic signed [WKEY_W-1:0] out_tree_weight,
  output logic signed [COST_W-1:0] out_running_cost,
  output logic                     out_has_edge,
  output logic                     out_edges_dropped,
  output logic                     out_run_end
);

  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int WB_EFF = (WEIGHT_BITS < WKEY_W) ? WEIGHT_BITS : WKEY_W;
  localparam int WSH    = WKEY_W - WB_EFF;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_WRD   = 4'd2;
  localparam logic [3:0] S_WCHK  = 4'd3;
  localparam logic [3:0] S_JOIN1 = 4'd4;
  localparam logic [3:0] S_JOIN2 = 4'd5;
  localparam logic [3:0] S_PUSH  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]              state_r, state_nxt;
  logic [ECNT_W-1:0]       cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [ECNT_W-1:0]       sc_idx_r, sc_idx_nxt;
  logic                    rv_r, rv_nxt;
  logic                    found_r, found_nxt;
  logic                    have_prev_r, have_prev_nxt;
  logic [KEY_W-1:0]        best_r, best_nxt;
  logic [KEY_W-1:0]        prev_r, prev_nxt;
  logic [VTX_W-1:0]        cur_r, cur_nxt;
  logic                    walk_b_r, walk_b_nxt;
  logic [VTX_W-1:0]        ra_r, ra_nxt, rb_r, rb_nxt;
  logic [SIZE_W-1:0]       sa_r, sa_nxt, sb_r, sb_nxt;
  logic [MAX_VERTICES-1:0] vld_r, vld_nxt;
  logic signed [COST_W-1:0] cost_r, cost_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [KEY_W-1:0]        pend_key_r, pend_key_nxt;
  logic signed [COST_W-1:0] pend_cost_r, pend_cost_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]        out_key_r, out_key_nxt;
  logic signed [COST_W-1:0] out_cost_r, out_cost_nxt;
  logic                    out_has_r, out_has_nxt;
  logic                    out_drop_r, out_drop_nxt;
  logic                    out_end_r, out_end_nxt;

  // edge store port signals
  logic                    es_we;
  logic [EIDX_W-1:0]       es_waddr, es_raddr;
  logic [KEY_W-1:0]        es_wdata, es_rdata;
  // set store port signals
  logic                    ss_we;
  logic [VIDX_W-1:0]       ss_waddr, ss_raddr;
  set_ent_t                ss_wdata, ss_rdata;

  logic                    out_free;
  logic                    in_xfer;
  logic                    in_range;
  logic signed [WKEY_W-1:0] w_ext;
  logic [KEY_W-1:0]        in_key;
  logic                    cand;
  logic [VTX_W-1:0]        walk_par;
  logic [SIZE_W-1:0]       walk_size;
  logic [VTX_W-1:0]        big_v, small_v;
  logic [SIZE_W-1:0]       small_sz;
  logic signed [WKEY_W-1:0] cur_w;
  logic signed [COST_W:0]  cost_sum;
  logic signed [COST_W-1:0] cost_sat;

  kmst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES), .AW(EIDX_W)) u_edge_ram (
    .clk   (clk),
    .we    (es_we),
    .waddr (es_waddr),
    .wdata (es_wdata),
    .raddr (es_raddr),
    .rdata (es_rdata)
  );

  kmst_ram #(.WIDTH(SET_W), .DEPTH(MAX_VERTICES), .AW(VIDX_W)) u_set_ram (
    .clk   (clk),
    .we    (ss_we),
    .waddr (ss_waddr),
    .wdata (ss_wdata),
    .raddr (ss_raddr),
    .rdata (ss_rdata)
  );

  // input decode: narrow weight, range check, sortable key
  assign w_ext    = (in_edge_weight <<< WSH) >>> WSH;
  assign in_range = ({1'b0, in_src_vertex} < (VTX_W + 1)'(MAX_VERTICES)) &&
                    ({1'b0, in_dst_vertex} < (VTX_W + 1)'(MAX_VERTICES));
  assign in_key   = {w_ext ^ WKEY_FLIP, in_src_vertex, in_dst_vertex};
  assign in_stall = (state_r != S_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // scan compare: smallest key above the previous one
  assign cand = (!have_prev_r || (es_rdata > prev_r)) && (!found_r || (es_rdata < best_r));

  // root walk: an entry never written is its own root of size one
  assign walk_par  = vld_r[cur_r[VIDX_W-1:0]] ? ss_rdata.parent : cur_r;
  assign walk_size = vld_r[cur_r[VIDX_W-1:0]] ? ss_rdata.size : SIZE_W'(1);

  // union by size
  assign big_v    = (sa_r < sb_r) ? rb_r : ra_r;
  assign small_v  = (sa_r < sb_r) ? ra_r : rb_r;
  assign small_sz = (sa_r < sb_r) ? sa_r : sb_r;

  // saturating cost update
  assign cur_w    = signed'(best_r[KEY_W-1 -: WKEY_W] ^ WKEY_FLIP);
  assign cost_sum = (COST_W + 1)'(cost_r) + (COST_W + 1)'(cur_w);
  always_comb begin
    if (cost_sum[COST_W] != cost_sum[COST_W-1]) begin
      cost_sat = cost_sum[COST_W] ? {1'b1, {(COST_W - 1){1'b0}}}
                                  : {1'b0, {(COST_W - 1){1'b1}}};
    end else begin
      cost_sat = cost_sum[COST_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    sc_idx_nxt    = sc_idx_r;
    rv_nxt        = 1'b0;
    found_nxt     = found_r;
    have_prev_nxt = have_prev_r;
    best_nxt      = best_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    walk_b_nxt    = walk_b_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    vld_nxt       = vld_r;
    cost_nxt      = cost_r;
    pend_v_nxt    = pend_v_r;
    pend_key_nxt  = pend_key_r;
    pend_cost_nxt = pend_cost_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_key_nxt   = out_key_r;
    out_cost_nxt  = out_cost_r;
    out_has_nxt   = out_has_r;
    out_drop_nxt  = out_drop_r;
    out_end_nxt   = out_end_r;
    es_we         = 1'b0;
    es_waddr      = cnt_r[EIDX_W-1:0];
    es_wdata      = in_key;
    es_raddr      = sc_idx_r[EIDX_W-1:0];
    ss_we         = 1'b0;
    ss_waddr      = small_v[VIDX_W-1:0];
    ss_wdata      = '{size: small_sz, parent: big_v};
    ss_raddr      = cur_r[VIDX_W-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (in_range) begin
            if (cnt_r < ECNT_W'(MAX_EDGES)) begin
              es_we   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_last_edge) begin
            state_nxt     = S_SCAN;
            sc_idx_nxt    = '0;
            found_nxt     = 1'b0;
            have_prev_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (sc_idx_r < cnt_r) begin
          sc_idx_nxt = sc_idx_r + 1'b1;
          rv_nxt     = 1'b1;
        end
        if (rv_r && cand) begin
          found_nxt = 1'b1;
          best_nxt  = es_rdata;
        end
        if (sc_idx_r == cnt_r && !rv_r) begin
          if (found_r) begin
            prev_nxt      = best_r;
            have_prev_nxt = 1'b1;
            cur_nxt       = best_r[2*VTX_W-1:VTX_W];
            walk_b_nxt    = 1'b0;
            state_nxt     = S_WRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WRD: begin
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (walk_par != cur_r) begin
          cur_nxt   = walk_par;
          state_nxt = S_WRD;
        end else if (!walk_b_r) begin
          ra_nxt     = cur_r;
          sa_nxt     = walk_size;
          walk_b_nxt = 1'b1;
          cur_nxt    = best_r[VTX_W-1:0];
          state_nxt  = S_WRD;
        end else if (cur_r == ra_r) begin
          // endpoints already joined: next pass
          state_nxt  = S_SCAN;
          sc_idx_nxt = '0;
          found_nxt  = 1'b0;
        end else begin
          rb_nxt    = cur_r;
          sb_nxt    = walk_size;
          state_nxt = S_JOIN1;
        end
      end
      S_JOIN1: begin
        ss_we                          = 1'b1;
        vld_nxt[small_v[VIDX_W-1:0]]   = 1'b1;
        state_nxt                      = S_JOIN2;
      end
      S_JOIN2: begin
        ss_we                        = 1'b1;
        ss_waddr                     = big_v[VIDX_W-1:0];
        ss_wdata                     = '{size: sa_r + sb_r, parent: big_v};
        vld_nxt[big_v[VIDX_W-1:0]]   = 1'b1;
        cost_nxt                     = cost_sat;
        state_nxt                    = S_PUSH;
      end
      S_PUSH: begin
        // the held result leaves once a newer tree edge is known
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_key_nxt   = pend_key_r;
            out_cost_nxt  = pend_cost_r;
            out_has_nxt   = 1'b1;
            out_drop_nxt  = ovf_r;
            out_end_nxt   = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_key_nxt  = best_r;
          pend_cost_nxt = cost_r;
          state_nxt     = S_SCAN;
          sc_idx_nxt    = '0;
          found_nxt     = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = pend_v_r ? pend_key_r : {WKEY_FLIP, {(2 * VTX_W){1'b0}}};
          out_cost_nxt  = pend_v_r ? pend_cost_r : '0;
          out_has_nxt   = pend_v_r;
          out_drop_nxt  = ovf_r;
          out_end_nxt   = 1'b1;
          // clear graph for the next run
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          cost_nxt      = '0;
          vld_nxt       = '0;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sc_idx_r    <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      walk_b_r    <= 1'b0;
      vld_r       <= '0;
      cost_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      sc_idx_r    <= sc_idx_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      have_prev_r <= have_prev_nxt;
      walk_b_r    <= walk_b_nxt;
      vld_r       <= vld_nxt;
      cost_r      <= cost_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    sa_r        <= sa_nxt;
    sb_r        <= sb_nxt;
    pend_key_r  <= pend_key_nxt;
    pend_cost_r <= pend_cost_nxt;
    out_key_r   <= out_key_nxt;
    out_cost_r  <= out_cost_nxt;
    out_has_r   <= out_has_nxt;
    out_drop_r  <= out_drop_nxt;
    out_end_r   <= out_end_nxt;
  end

  // result port
  assign out_valid         = out_valid_r;
  assign out_tree_src      = out_key_r[2*VTX_W-1:VTX_W];
  assign out_tree_dst      = out_key_r[VTX_W-1:0];
  assign out_tree_weight   = signed'(out_key_r[KEY_W-1 -: WKEY_W] ^ WKEY_FLIP);
  assign out_running_cost  = out_cost_r;
  assign out_has_edge      = out_has_r;
  assign out_edges_dropped = out_drop_r;
  assign out_run_end       = out_end_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ECNT_W'(MAX_EDGES))
    else $error("edge count above capacity");

  a_join_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_JOIN1 |-> ra_r != rb_r)
    else $error("join of a set with itself");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_end_r)
    else $error("empty result not marked as run end");

  a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_free |=> cnt_r == '0 && vld_r == '0 && !pend_v_r)
    else $error("graph not cleared after run");

endmodule

### tb/kruskal_minimum_spanning_tree_checker.sv
`timescale 1ns / 1ps
module kruskal_minimum_spanning_tree_checker
  import kmst_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [VTX_W-1:0]         in_src_vertex,
  input  logic [VTX_W-1:0]         in_dst_vertex,
  input  logic signed [WKEY_W-1:0] in_edge_weight,
  input  logic                     in_last_edge,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [VTX_W-1:0]         out_tree_src,
  input  logic [VTX_W-1:0]         out_tree_dst,
  input  logic signed [WKEY_W-1:0] out_tree_weight,
  input  logic signed [COST_W-1:0] out_running_cost,
  input  logic                     out_has_edge,
  input  logic                     out_edges_dropped,
  input  logic                     out_run_end,
  output int                       fail_count,
  output int                       tree_edges_pending
);

  typedef struct packed {
    logic [VTX_W-1:0]         src;
    logic [VTX_W-1:0]         dst;
    logic signed [WKEY_W-1:0] weight;
    logic signed [COST_W-1:0] cost;
    logic                     has_edge;
    logic                     dropped;
    logic                     run_end;
  } tree_edge_t;

  tree_edge_t       tree_edge_q[$];
  logic [KEY_W-1:0] graph_keys[$];
  logic [VTX_W-1:0] forest_parent[64];
  int               forest_size[64];
  logic             graph_overflow;
  int               mismatch_count;

  assign tree_edges_pending = tree_edge_q.size();

  function automatic int find_root(int v);
    int r;
    int cur;
    int nxt;
    r = v;
    cur = v;
    while (forest_parent[r] != r) r = forest_parent[r];
    // path compression
    while (forest_parent[cur] != cur) begin
      nxt = forest_parent[cur];
      forest_parent[cur] = r[VTX_W-1:0];
      cur = nxt;
    end
    return r;
  endfunction

  // sort the graph, run union-find, queue each accepted tree edge (or one empty result), mark the last as run end
  task automatic build_spanning_tree();
    logic [KEY_W-1:0] keys[$];
    tree_edge_t       te;
    longint           cost;
    int               a;
    int               b;
    int               t;
    int               made;
    keys = graph_keys;
    keys.sort();
    for (int v = 0; v < 64; v++) begin
      forest_parent[v] = v[VTX_W-1:0];
      forest_size[v] = 1;
    end
    cost = 0;
    made = 0;
    foreach (keys[i]) begin
      a = find_root(keys[i][2*VTX_W-1:VTX_W]);
      b = find_root(keys[i][VTX_W-1:0]);
      if (a != b) begin
        cost += longint'($signed(keys[i][KEY_W-1:2*VTX_W] ^ WKEY_FLIP));
        if (cost > 2097151) cost = 2097151;
        if (cost < -2097152) cost = -2097152;
        if (forest_size[a] < forest_size[b]) begin
          t = a;
          a = b;
          b = t;
        end
        forest_parent[b] = a[VTX_W-1:0];
        forest_size[a] += forest_size[b];
        te.src = keys[i][2*VTX_W-1:VTX_W];
        te.dst = keys[i][VTX_W-1:0];
        te.weight = keys[i][KEY_W-1:2*VTX_W] ^ WKEY_FLIP;
        te.cost = cost[COST_W-1:0];
        te.has_edge = 1'b1;
        te.dropped = graph_overflow;
        te.run_end = 1'b0;
        tree_edge_q.insert(tree_edge_q.size(), te);
        made++;
      end
    end
    if (made == 0) begin
      te = '0;
      te.dropped = graph_overflow;
      tree_edge_q.insert(tree_edge_q.size(), te);
    end
    tree_edge_q[$].run_end = 1'b1;
    graph_keys.delete();
    graph_overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    logic signed [WKEY_W-1:0] w;
    tree_edge_t               exp_te;
    tree_edge_t               got_te;
    if (!rst_n) begin
      tree_edge_q.delete();
      graph_keys.delete();
      graph_overflow = 1'b0;
      mismatch_count = 0;
      fail_count <= 0;
    end else begin
      // result transfer
      if (out_valid && !out_stall) begin
        got_te = {out_tree_src, out_tree_dst, out_tree_weight, out_running_cost,
                  out_has_edge, out_edges_dropped, out_run_end};
        if (tree_edge_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result %p", $time, got_te);
        end else begin
          exp_te = tree_edge_q.pop_front();
          if (got_te !== exp_te) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch expected %p actual %p", $time, exp_te, got_te);
          end
        end
      end
      // edge transfer
      if (in_valid && !in_stall) begin
        w = in_edge_weight;
        if (WEIGHT_BITS < WKEY_W)
          w = (w <<< (WKEY_W - WEIGHT_BITS)) >>> (WKEY_W - WEIGHT_BITS);
        if (in_src_vertex < MAX_VERTICES && in_dst_vertex < MAX_VERTICES) begin
          if (graph_keys.size() < MAX_EDGES)
            graph_keys.insert(graph_keys.size(), {w ^ WKEY_FLIP, in_src_vertex, in_dst_vertex});
          else
            graph_overflow = 1'b1;
        end
        if (in_last_edge) build_spanning_tree();
      end
      fail_count <= mismatch_count;
    end
  end

endmodule

### tb/kruskal_minimum_spanning_tree_unit_tb.sv
`timescale 1ns / 1ps
module kruskal_minimum_spanning_tree_unit_tb;
  import kmst_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [VTX_W-1:0]         in_src_vertex;
  logic [VTX_W-1:0]         in_dst_vertex;
  logic signed [WKEY_W-1:0] in_edge_weight;
  logic                     in_last_edge;
  logic                     out_valid;
  logic                     out_stall;
  logic [VTX_W-1:0]         out_tree_src;
  logic [VTX_W-1:0]         out_tree_dst;
  logic signed [WKEY_W-1:0] out_tree_weight;
  logic signed [COST_W-1:0] out_running_cost;
  logic                     out_has_edge;
  logic                     out_edges_dropped;
  logic                     out_run_end;
  int                       fail_count;
  int                       tree_edges_pending;
  int                       idle_cycles;
  logic                     hold_results;

  kruskal_minimum_spanning_tree_unit u_dut (.*);

  kruskal_minimum_spanning_tree_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("kruskal_minimum_spanning_tree_unit_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_results && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      out_stall <= (gap != 0);
      repeat (gap) @(posedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one edge transfer, gap drawn per item, valid held across back-to-back items
  task automatic send_edge(int s, int d, int w, bit last, bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_vertex <= s[VTX_W-1:0];
    in_dst_vertex <= d[VTX_W-1:0];
    in_edge_weight <= w[WKEY_W-1:0];
    in_last_edge <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tree_edges_pending != 0) @(posedge clk);
  endtask

  // random graph over a small vertex window so the forest actually merges
  task automatic random_graph(int n_edges, int span, bit busy);
    int base;
    int w;
    base = $urandom_range(0, 64 - span);
    for (int i = 0; i < n_edges; i++) begin
      case ($urandom_range(0, 3))
        0: w = $urandom_range(0, 65535);
        1: w = $urandom_range(0, 7);
        2: w = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        default: w = $urandom_range(0, 255) - 128;
      endcase
      send_edge(base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1),
                w, i == n_edges - 1, busy);
    end
  endtask

  initial begin
    hold_results = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_src_vertex <= '0;
    in_dst_vertex <= '0;
    in_edge_weight <= '0;
    in_last_edge <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone self loop: empty tree
    send_edge(5, 5, 100, 1, 0);
    // extremes of vertices and weights, duplicates and a tie on weight
    send_edge(63, 0, 32767, 0, 0);
    send_edge(0, 63, -32768, 0, 0);
    send_edge(63, 0, -32768, 0, 0);
    send_edge(42, 21, -1, 0, 0);
    send_edge(21, 42, 0, 0, 0);
    send_edge(0, 42, -1, 0, 0);
    send_edge(63, 63, 1, 1, 0);
    // long chains of extreme weights, both signs
    for (int i = 0; i < 32; i++) send_edge(i, i + 1, 32767, i == 31, 1);
    drain_results();
    for (int i = 0; i < 32; i++) send_edge(i + 1, i, -32768, i == 31, 0);
    drain_results();

    // long receiver hold-off while edges keep coming
    hold_results = 1'b1;
    random_graph(10, 12, 1);
    random_graph(10, 12, 1);
    random_graph(10, 12, 1);
    random_graph(10, 12, 1);

    // sender pauses until everything is back
    drain_results();
    repeat (6) random_graph($urandom_range(1, 8), $urandom_range(2, 16), 0);
    random_graph(20, 64, 0);

    drain_results();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && tree_edges_pending == 0) begin
      $display("kruskal_minimum_spanning_tree_unit_tb: PASS");
    end else begin
      $display("kruskal_minimum_spanning_tree_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
